// File: rtl/vag_pkg.sv
// ----------------------------------------------------------------------------
// Voice addressability gate package
// Shared constants, codes and pipeline payload types of the gate.
// ----------------------------------------------------------------------------
package vag_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;

  localparam int IN_W   = 13;
  localparam int CFG_W  = 13;
  localparam int CNT_W  = 3;
  localparam int IDX_W  = 3;
  localparam int UNIT_W = FRAC_BITS + 1;
  localparam int CMP_W  = (UNIT_W > IN_W) ? UNIT_W : IN_W;
  localparam int FSUM_W = FRAC_BITS + 2;
  localparam int PROD_W = 2 * FRAC_BITS + 1;
  localparam int ACC_W  = 2 * FRAC_BITS + 3;
  localparam int DIV_K  = FRAC_BITS + 4;
  localparam int DIV_R  = ((1 << DIV_K) + 2) / 3;
  localparam int DPROD_W = FSUM_W + DIV_K;

  localparam int W_10 = (10 * ONE + 50) / 100;
  localparam int W_12 = (12 * ONE + 50) / 100;
  localparam int W_16 = (16 * ONE + 50) / 100;
  localparam int W_18 = (18 * ONE + 50) / 100;
  localparam int W_20 = (20 * ONE + 50) / 100;
  localparam int W_22 = (22 * ONE + 50) / 100;
  localparam int W_25 = (25 * ONE + 50) / 100;
  localparam int W_34 = (34 * ONE + 50) / 100;
  localparam int W_38 = (38 * ONE + 50) / 100;
  localparam int W_55 = (55 * ONE + 50) / 100;
  localparam int W_62 = (62 * ONE + 50) / 100;
  localparam int W_78 = (78 * ONE + 50) / 100;
  localparam int W_85 = (85 * ONE + 50) / 100;

  localparam int RST_FAMILY_THR  = (60 * ONE + 50) / 100;
  localparam int RST_ACCEPT_LVL  = (70 * ONE + 50) / 100;
  localparam int RST_REJECT_LVL  = (30 * ONE + 50) / 100;
  localparam int RST_MEDIA_LVL   = (80 * ONE + 50) / 100;
  localparam int RST_OVERLAP_LVL = (80 * ONE + 50) / 100;
  localparam int RST_MIN_FAM     = 2;

  localparam logic [IDX_W-1:0] CFG_FAMILY_THR  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ACCEPT_LVL  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_REJECT_LVL  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_MEDIA_LVL   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_OVERLAP_LVL = 3'd4;
  localparam logic [IDX_W-1:0] CFG_MIN_FAM     = 3'd5;

  typedef logic [UNIT_W-1:0] unit_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef enum logic [1:0] {
    PATH_EXPLICIT,
    PATH_VETO,
    PATH_FOLLOWUP,
    PATH_SCORED
  } path_e;

  typedef enum logic [1:0] {
    DEC_ACCEPT  = 2'd0,
    DEC_REJECT  = 2'd1,
    DEC_ABSTAIN = 2'd2
  } decision_e;

  typedef enum logic [1:0] {
    BAND_LOW      = 2'd0,
    BAND_MEDIUM   = 2'd1,
    BAND_HIGH     = 2'd2,
    BAND_EXPLICIT = 2'd3
  } band_e;

  typedef enum logic [2:0] {
    RSN_EXPLICIT     = 3'd0,
    RSN_NEGATIVE     = 3'd1,
    RSN_MEDIA_VETO   = 3'd2,
    RSN_OVERLAP_VETO = 3'd3,
    RSN_FOLLOWUP     = 3'd4,
    RSN_MULTI_ACCEPT = 3'd5,
    RSN_LOW_REJECT   = 3'd6,
    RSN_UNCERTAIN    = 3'd7
  } reason_e;

  typedef struct packed {
    logic [CFG_W-1:0] family_thr;
    logic [CFG_W-1:0] accept_lvl;
    logic [CFG_W-1:0] reject_lvl;
    logic [CFG_W-1:0] media_lvl;
    logic [CFG_W-1:0] overlap_lvl;
    logic [CNT_W-1:0] min_fam;
  } cfg_t;

  typedef struct packed {
    logic [IN_W-1:0] intent;
    logic [IN_W-1:0] prox;
    logic [IN_W-1:0] asr;
    logic [IN_W-1:0] spk;
    logic [IN_W-1:0] media;
    logic [IN_W-1:0] overlap;
    logic            expl;
    logic            neg;
    logic            fwin;
    logic            fmatch;
    logic            direct;
    logic            recent;
  } evid_t;

  typedef struct packed {
    path_e             path;
    reason_e           reason;
    logic [CNT_W-1:0]  fam;
    unit_t             intent;
    unit_t             prox;
    unit_t             asr;
    unit_t             spk;
    unit_t             media;
    unit_t             overlap;
    logic [FSUM_W-1:0] fsum;
    logic              direct;
    logic              recent;
    logic              fwin;
  } prep_t;

  typedef struct packed {
    path_e            path;
    reason_e          reason;
    logic [CNT_W-1:0] fam;
    unit_t            fq;
    prod_t            p_intent;
    prod_t            p_prox;
    prod_t            p_asr;
    prod_t            p_spk;
    prod_t            p_media;
    prod_t            p_overlap;
    prod_t            bias;
  } weigh_t;

  typedef struct packed {
    path_e            path;
    reason_e          reason;
    logic [CNT_W-1:0] fam;
    unit_t            score;
  } score_t;

  typedef struct packed {
    decision_e        decision;
    band_e            band;
    unit_t            score;
    logic [CNT_W-1:0] fam;
    reason_e          reason;
  } verdict_t;

  function automatic logic unit_ge(unit_t a, logic [CFG_W-1:0] b);
    return CMP_W'(a) >= CMP_W'(b);
  endfunction

endpackage

// File: rtl/vag_if.sv
// ----------------------------------------------------------------------------
// Voice addressability gate channels
// Evidence and verdict channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface vag_evid_if import vag_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] intent_score;
  logic [IN_W-1:0] proximity_score;
  logic [IN_W-1:0] recog_confidence;
  logic [IN_W-1:0] speaker_score;
  logic [IN_W-1:0] media_score;
  logic [IN_W-1:0] overlap_score;
  logic            explicit_flag;
  logic            negative_flag;
  logic            followup_window;
  logic            followup_match;
  logic            direct_flag;
  logic            recent_flag;

  modport source (
    output valid, intent_score, proximity_score, recog_confidence, speaker_score,
           media_score, overlap_score, explicit_flag, negative_flag, followup_window,
           followup_match, direct_flag, recent_flag,
    input  ready
  );

  modport sink (
    input  valid, intent_score, proximity_score, recog_confidence, speaker_score,
           media_score, overlap_score, explicit_flag, negative_flag, followup_window,
           followup_match, direct_flag, recent_flag,
    output ready
  );
endinterface

interface vag_verdict_if import vag_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       decision;
  logic [1:0]       band;
  logic [IN_W-1:0]  score_out;
  logic [CNT_W-1:0] family_count;
  logic [2:0]       reason;

  modport source (
    output valid, decision, band, score_out, family_count, reason,
    input  ready
  );

  modport sink (
    input  valid, decision, band, score_out, family_count, reason,
    output ready
  );
endinterface

// File: rtl/vag_prep.sv
// ----------------------------------------------------------------------------
// Voice addressability gate, stage one
// Clamps the scores, resolves explicit, veto and follow-up paths and counts
// the positive families.
// ----------------------------------------------------------------------------
module vag_prep import vag_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   valid_i,
  output logic   ready_o,
  input  evid_t  data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output prep_t  data_o
);

  logic  valid_q;
  prep_t data_q, data_d;
  unit_t intent, prox, asr, spk, media, overlap;
  logic  media_hit, overlap_hit, followup;

  function automatic unit_t clamp(logic [IN_W-1:0] x);
    return (CMP_W'(x) > CMP_W'(ONE)) ? UNIT_W'(ONE) : UNIT_W'(x);
  endfunction

  always_comb begin
    intent  = clamp(data_i.intent);
    prox    = clamp(data_i.prox);
    asr     = clamp(data_i.asr);
    spk     = clamp(data_i.spk);
    media   = clamp(data_i.media);
    overlap = clamp(data_i.overlap);

    media_hit   = unit_ge(media, cfg_i.media_lvl);
    overlap_hit = unit_ge(overlap, cfg_i.overlap_lvl);
    followup    = data_i.fwin && data_i.fmatch &&
                  (media < UNIT_W'(W_55)) && (overlap < UNIT_W'(W_55));

    data_d         = '0;
    data_d.intent  = intent;
    data_d.prox    = prox;
    data_d.asr     = asr;
    data_d.spk     = spk;
    data_d.media   = media;
    data_d.overlap = overlap;
    data_d.direct  = data_i.direct;
    data_d.recent  = data_i.recent;
    data_d.fwin    = data_i.fwin;
    data_d.fsum    = FSUM_W'(intent) + FSUM_W'(asr) + FSUM_W'(ONE);
    data_d.fam     = CNT_W'($countones({data_i.direct, data_i.recent,
                                        unit_ge(intent, cfg_i.family_thr),
                                        unit_ge(prox, cfg_i.family_thr),
                                        unit_ge(asr, cfg_i.family_thr),
                                        unit_ge(spk, cfg_i.family_thr)}));
    data_d.reason  = RSN_UNCERTAIN;

    if (data_i.expl) begin
      data_d.path   = PATH_EXPLICIT;
      data_d.reason = RSN_EXPLICIT;
    end else if (data_i.neg || media_hit || overlap_hit) begin
      data_d.path   = PATH_VETO;
      data_d.reason = data_i.neg ? RSN_NEGATIVE :
                      (media_hit ? RSN_MEDIA_VETO : RSN_OVERLAP_VETO);
    end else if (followup) begin
      data_d.path   = PATH_FOLLOWUP;
      data_d.reason = RSN_FOLLOWUP;
    end else begin
      data_d.path   = PATH_SCORED;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// File: rtl/vag_weigh.sv
// ----------------------------------------------------------------------------
// Voice addressability gate, stage two
// Forms the weighted products, the flag bias and the follow-up third.
// ----------------------------------------------------------------------------
module vag_weigh import vag_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  prep_t  data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output weigh_t data_o
);

  logic                valid_q;
  weigh_t              data_q, data_d;
  logic [DPROD_W-1:0]  dprod;

  always_comb begin
    dprod = DPROD_W'(data_i.fsum) * DPROD_W'(DIV_R);

    data_d.path      = data_i.path;
    data_d.reason    = data_i.reason;
    data_d.fam       = data_i.fam;
    data_d.fq        = UNIT_W'(dprod >> DIV_K);
    data_d.p_intent  = PROD_W'(data_i.intent)  * PROD_W'(W_34);
    data_d.p_prox    = PROD_W'(data_i.prox)    * PROD_W'(W_18);
    data_d.p_asr     = PROD_W'(data_i.asr)     * PROD_W'(W_16);
    data_d.p_spk     = PROD_W'(data_i.spk)     * PROD_W'(W_10);
    data_d.p_media   = PROD_W'(data_i.media)   * PROD_W'(W_25);
    data_d.p_overlap = PROD_W'(data_i.overlap) * PROD_W'(W_20);
    data_d.bias      = (data_i.direct ? PROD_W'(W_18 * ONE) : '0) +
                       (data_i.recent ? PROD_W'(W_12 * ONE) : '0) +
                       (data_i.fwin   ? PROD_W'(W_10 * ONE) : '0);
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// File: rtl/vag_score.sv
// ----------------------------------------------------------------------------
// Voice addressability gate, stage three
// Sums the weighted terms, floors and saturates the score and selects the
// score of each decision path.
// ----------------------------------------------------------------------------
module vag_score import vag_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  weigh_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output score_t data_o
);

  logic                          valid_q;
  score_t                        data_q, data_d;
  logic        [ACC_W-1:0]       pos, neg;
  logic signed [ACC_W-1:0]       acc;
  logic        [ACC_W-FRAC_BITS-1:0] whole;
  unit_t                         wscore, fscore;

  always_comb begin
    pos = ACC_W'(data_i.p_intent) + ACC_W'(data_i.p_prox) + ACC_W'(data_i.p_asr) +
          ACC_W'(data_i.p_spk) + ACC_W'(data_i.bias);
    neg = ACC_W'(data_i.p_media) + ACC_W'(data_i.p_overlap);
    acc = signed'(pos) - signed'(neg);
    whole = acc[ACC_W-1:FRAC_BITS];

    if (acc[ACC_W-1]) begin
      wscore = '0;
    end else if (whole > (ACC_W-FRAC_BITS)'(ONE)) begin
      wscore = UNIT_W'(ONE);
    end else begin
      wscore = UNIT_W'(whole);
    end

    fscore = (data_i.fq < UNIT_W'(W_85)) ? UNIT_W'(W_85) : data_i.fq;

    data_d.path   = data_i.path;
    data_d.reason = data_i.reason;
    data_d.fam    = data_i.fam;
    case (data_i.path)
      PATH_EXPLICIT: data_d.score = UNIT_W'(ONE);
      PATH_VETO:     data_d.score = '0;
      PATH_FOLLOWUP: data_d.score = fscore;
      default:       data_d.score = wscore;
    endcase
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// File: rtl/vag_decide.sv
// ----------------------------------------------------------------------------
// Voice addressability gate, stage four
// Applies the accept and reject levels, grades the confidence band and holds
// the verdict in the output register.
// ----------------------------------------------------------------------------
module vag_decide import vag_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     valid_i,
  output logic     ready_o,
  input  score_t   data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output verdict_t data_o
);

  logic     valid_q;
  verdict_t data_q, data_d;
  band_e    grade;
  logic     accept_ok;

  always_comb begin
    if ((data_i.score >= UNIT_W'(W_78)) || (data_i.score <= UNIT_W'(W_22))) begin
      grade = BAND_HIGH;
    end else if ((data_i.score >= UNIT_W'(W_62)) || (data_i.score <= UNIT_W'(W_38))) begin
      grade = BAND_MEDIUM;
    end else begin
      grade = BAND_LOW;
    end

    accept_ok = unit_ge(data_i.score, cfg_i.accept_lvl) && (data_i.fam >= cfg_i.min_fam);

    data_d.score  = data_i.score;
    data_d.reason = data_i.reason;
    case (data_i.path)
      PATH_EXPLICIT: begin
        data_d.decision = DEC_ACCEPT;
        data_d.band     = BAND_EXPLICIT;
        data_d.fam      = CNT_W'(1);
      end
      PATH_VETO: begin
        data_d.decision = DEC_REJECT;
        data_d.band     = BAND_HIGH;
        data_d.fam      = '0;
      end
      PATH_FOLLOWUP: begin
        data_d.decision = DEC_ACCEPT;
        data_d.band     = BAND_HIGH;
        data_d.fam      = CNT_W'(2);
      end
      default: begin
        data_d.band = grade;
        data_d.fam  = data_i.fam;
        if (accept_ok) begin
          data_d.decision = DEC_ACCEPT;
          data_d.reason   = RSN_MULTI_ACCEPT;
        end else if (!unit_ge(data_i.score, cfg_i.reject_lvl) ||
                     (CMP_W'(data_i.score) == CMP_W'(cfg_i.reject_lvl))) begin
          data_d.decision = DEC_REJECT;
          data_d.reason   = RSN_LOW_REJECT;
        end else begin
          data_d.decision = DEC_ABSTAIN;
          data_d.reason   = RSN_UNCERTAIN;
        end
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  a_taken_is_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> valid_q)
    else $error("accepted word did not reach the output register");

  a_explicit_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (data_q.reason == RSN_EXPLICIT) |->
      (data_q.decision == DEC_ACCEPT) && (data_q.band == BAND_EXPLICIT) &&
      (data_q.fam == CNT_W'(1)) && (data_q.score == UNIT_W'(ONE)))
    else $error("explicit verdict malformed");

  a_veto_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ((data_q.reason == RSN_NEGATIVE) || (data_q.reason == RSN_MEDIA_VETO) ||
                (data_q.reason == RSN_OVERLAP_VETO)) |->
      (data_q.decision == DEC_REJECT) && (data_q.score == '0) && (data_q.fam == '0))
    else $error("veto verdict malformed");

  a_followup_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (data_q.reason == RSN_FOLLOWUP) |->
      (data_q.score >= UNIT_W'(W_85)) && (data_q.score <= UNIT_W'(ONE)))
    else $error("follow-up score out of range");

endmodule

// File: rtl/voice_addressability_gate.sv
// ----------------------------------------------------------------------------
// Voice addressability gate
// Decides per utterance whether speech is addressed to the assistant.
// ----------------------------------------------------------------------------
// Channel   | Direction | Word
// evid_i    | in        | six Q12 scores and six flags of one utterance
// verdict_o | out       | decision, band, score, family count and reason
// cfg       | in        | write enable, register index, write data
//
// One word is accepted per cycle while prep is not held by a stall; each
// word passes the four register stages prep, weigh, score and decide.
// Reset clears the stage valid bits and loads the default register values.
// A stall holds each full stage, while empty stages ahead still take words.
// ----------------------------------------------------------------------------
module voice_addressability_gate import vag_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  vag_evid_if.sink         evid_i,
  vag_verdict_if.source    verdict_o
);

  cfg_t     cfg_q, cfg_d;
  evid_t    evid;
  prep_t    prep;
  weigh_t   weigh;
  score_t   score;
  verdict_t verdict;
  logic     prep_valid, prep_ready;
  logic     weigh_valid, weigh_ready;
  logic     score_valid, score_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FAMILY_THR:  cfg_d.family_thr  = cfg_data_i;
        CFG_ACCEPT_LVL:  cfg_d.accept_lvl  = cfg_data_i;
        CFG_REJECT_LVL:  cfg_d.reject_lvl  = cfg_data_i;
        CFG_MEDIA_LVL:   cfg_d.media_lvl   = cfg_data_i;
        CFG_OVERLAP_LVL: cfg_d.overlap_lvl = cfg_data_i;
        CFG_MIN_FAM:     cfg_d.min_fam     = cfg_data_i[CNT_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.family_thr  <= CFG_W'(RST_FAMILY_THR);
      cfg_q.accept_lvl  <= CFG_W'(RST_ACCEPT_LVL);
      cfg_q.reject_lvl  <= CFG_W'(RST_REJECT_LVL);
      cfg_q.media_lvl   <= CFG_W'(RST_MEDIA_LVL);
      cfg_q.overlap_lvl <= CFG_W'(RST_OVERLAP_LVL);
      cfg_q.min_fam     <= CNT_W'(RST_MIN_FAM);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign evid.intent  = evid_i.intent_score;
  assign evid.prox    = evid_i.proximity_score;
  assign evid.asr     = evid_i.recog_confidence;
  assign evid.spk     = evid_i.speaker_score;
  assign evid.media   = evid_i.media_score;
  assign evid.overlap = evid_i.overlap_score;
  assign evid.expl    = evid_i.explicit_flag;
  assign evid.neg     = evid_i.negative_flag;
  assign evid.fwin    = evid_i.followup_window;
  assign evid.fmatch  = evid_i.followup_match;
  assign evid.direct  = evid_i.direct_flag;
  assign evid.recent  = evid_i.recent_flag;

  vag_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (evid_i.valid),
    .ready_o (evid_i.ready),
    .data_i  (evid),
    .valid_o (prep_valid),
    .ready_i (prep_ready),
    .data_o  (prep)
  );

  vag_weigh u_weigh (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .data_i  (prep),
    .valid_o (weigh_valid),
    .ready_i (weigh_ready),
    .data_o  (weigh)
  );

  vag_score u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (weigh_valid),
    .ready_o (weigh_ready),
    .data_i  (weigh),
    .valid_o (score_valid),
    .ready_i (score_ready),
    .data_o  (score)
  );

  vag_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (score_valid),
    .ready_o (score_ready),
    .data_i  (score),
    .valid_o (verdict_o.valid),
    .ready_i (verdict_o.ready),
    .data_o  (verdict)
  );

  assign verdict_o.decision     = verdict.decision;
  assign verdict_o.band         = verdict.band;
  assign verdict_o.score_out    = IN_W'(verdict.score);
  assign verdict_o.family_count = verdict.fam;
  assign verdict_o.reason       = verdict.reason;

endmodule

// File: verif/vag_checker.sv
// ----------------------------------------------------------------------------
// Voice addressability gate checker
// Watches the register write port and both channels of the gate. It works out
// the verdict for every evidence word the gate takes. Each verdict the gate
// hands out is compared field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module vag_checker import vag_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  vag_evid_if              evid_i,
  vag_verdict_if           verdict_i,
  output int               errors_o,
  output int               pending_o,
  output int               compared_o,
  output logic [7:0]       reasons_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t     levels;
  verdict_t verdicts_due[$];

  function automatic longint wq(int hundredths);
    return (longint'(hundredths) * ONE + 50) / 100;
  endfunction

  function automatic longint clamp_q(logic [IN_W-1:0] raw);
    return (raw > ONE) ? longint'(ONE) : longint'(raw);
  endfunction

  function automatic band_e band_for(longint s);
    if (s >= wq(78) || s <= wq(22)) return BAND_HIGH;
    if (s >= wq(62) || s <= wq(38)) return BAND_MEDIUM;
    return BAND_LOW;
  endfunction

  function automatic verdict_t predict_verdict(evid_t e);
    longint   intent, prox, asr, spk, media, ovl, thr, acc, sc;
    int       fam;
    logic     media_hit, ovl_hit;
    verdict_t v;
    intent    = clamp_q(e.intent);
    prox      = clamp_q(e.prox);
    asr       = clamp_q(e.asr);
    spk       = clamp_q(e.spk);
    media     = clamp_q(e.media);
    ovl       = clamp_q(e.overlap);
    thr       = longint'(levels.family_thr);
    media_hit = media >= longint'(levels.media_lvl);
    ovl_hit   = ovl >= longint'(levels.overlap_lvl);
    if (e.expl) begin
      v = '{DEC_ACCEPT, BAND_EXPLICIT, UNIT_W'(ONE), CNT_W'(1), RSN_EXPLICIT};
      return v;
    end
    if (e.neg || media_hit || ovl_hit) begin
      v = '{DEC_REJECT, BAND_HIGH, UNIT_W'(0), CNT_W'(0),
            e.neg ? RSN_NEGATIVE : (media_hit ? RSN_MEDIA_VETO : RSN_OVERLAP_VETO)};
      return v;
    end
    if (e.fwin && e.fmatch && media < wq(55) && ovl < wq(55)) begin
      sc = (intent + asr + ONE) / 3;
      if (sc < wq(85)) sc = wq(85);
      v = '{DEC_ACCEPT, BAND_HIGH, UNIT_W'(sc), CNT_W'(2), RSN_FOLLOWUP};
      return v;
    end
    fam = int'(e.direct) + int'(e.recent) + int'(intent >= thr) + int'(prox >= thr)
        + int'(asr >= thr) + int'(spk >= thr);
    acc = (e.direct ? wq(18) * ONE : 0) + intent * wq(34) + prox * wq(18)
        + asr * wq(16) + spk * wq(10) + (e.recent ? wq(12) * ONE : 0)
        + (e.fwin ? wq(10) * ONE : 0) - media * wq(25) - ovl * wq(20);
    if (acc < 0) begin
      sc = 0;
    end else begin
      sc = acc >>> FRAC_BITS;
      if (sc > ONE) sc = ONE;
    end
    v.band  = band_for(sc);
    v.score = UNIT_W'(sc);
    v.fam   = CNT_W'(fam);
    if (sc >= longint'(levels.accept_lvl) && fam >= int'(levels.min_fam)) begin
      v.decision = DEC_ACCEPT;
      v.reason   = RSN_MULTI_ACCEPT;
    end else if (sc <= longint'(levels.reject_lvl)) begin
      v.decision = DEC_REJECT;
      v.reason   = RSN_LOW_REJECT;
    end else begin
      v.decision = DEC_ABSTAIN;
      v.reason   = RSN_UNCERTAIN;
    end
    return v;
  endfunction

  task automatic note_field(input string what, input logic [12:0] want_v,
                            input logic [12:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want_v, got_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    evid_t    ev;
    verdict_t want;
    if (!rst_ni) begin
      levels = '{13'd2458, 13'd2867, 13'd1229, 13'd3277, 13'd3277, 3'd2};
      verdicts_due.delete();
      errors_o   = 0;
      compared_o = 0;
      reasons_o  = '0;
    end else begin
      if (verdict_i.valid && verdict_i.ready) begin
        reasons_o[verdict_i.reason] = 1'b1;
        if (verdicts_due.size() == 0) begin
          $display("%0t ns: verdict with nothing outstanding: dec %0d band %0d score %0d fam %0d reason %0d",
                   $time, verdict_i.decision, verdict_i.band, verdict_i.score_out,
                   verdict_i.family_count, verdict_i.reason);
          errors_o++;
        end else begin
          want = verdicts_due.pop_front();
          note_field("decision", 13'(want.decision), 13'(verdict_i.decision));
          note_field("band", 13'(want.band), 13'(verdict_i.band));
          note_field("score", 13'(want.score), 13'(verdict_i.score_out));
          note_field("family count", 13'(want.fam), 13'(verdict_i.family_count));
          note_field("reason", 13'(want.reason), 13'(verdict_i.reason));
          compared_o++;
        end
      end
      if (evid_i.valid && evid_i.ready) begin
        ev.intent  = evid_i.intent_score;
        ev.prox    = evid_i.proximity_score;
        ev.asr     = evid_i.recog_confidence;
        ev.spk     = evid_i.speaker_score;
        ev.media   = evid_i.media_score;
        ev.overlap = evid_i.overlap_score;
        ev.expl    = evid_i.explicit_flag;
        ev.neg     = evid_i.negative_flag;
        ev.fwin    = evid_i.followup_window;
        ev.fmatch  = evid_i.followup_match;
        ev.direct  = evid_i.direct_flag;
        ev.recent  = evid_i.recent_flag;
        verdicts_due.push_back(predict_verdict(ev));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FAMILY_THR:  levels.family_thr  = cfg_data_i;
          CFG_ACCEPT_LVL:  levels.accept_lvl  = cfg_data_i;
          CFG_REJECT_LVL:  levels.reject_lvl  = cfg_data_i;
          CFG_MEDIA_LVL:   levels.media_lvl   = cfg_data_i;
          CFG_OVERLAP_LVL: levels.overlap_lvl = cfg_data_i;
          CFG_MIN_FAM:     levels.min_fam     = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = verdicts_due.size();
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Voice addressability gate testbench
// Drives the gate with a directed set of evidence words and then with random
// words across a series of register settings, extremes included. Both channels
// idle and stall at random; a side checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import vag_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES          = 10;
  localparam int WORDS_PER_PHASE = 195;

  localparam logic [IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam logic [5:0] F_NONE   = 6'b000000;
  localparam logic [5:0] F_EXPL   = 6'b100000;
  localparam logic [5:0] F_NEG    = 6'b010000;
  localparam logic [5:0] F_FWIN   = 6'b001000;
  localparam logic [5:0] F_FMATCH = 6'b000100;
  localparam logic [5:0] F_DIRECT = 6'b000010;
  localparam logic [5:0] F_RECENT = 6'b000001;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  int         errors, pending, compared;
  logic [7:0] reasons;
  int         words_sent, settings_used, hold_off;
  bit         src_calm, sink_calm;
  int         thr_f, lvl_m, lvl_o;

  vag_evid_if    evid();
  vag_verdict_if verdict();

  voice_addressability_gate i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .evid_i     (evid),
    .verdict_o  (verdict)
  );

  vag_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .evid_i     (evid),
    .verdict_i  (verdict),
    .errors_o   (errors),
    .pending_o  (pending),
    .compared_o (compared),
    .reasons_o  (reasons)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin : verdict_sink
    int draw;
    if (!rst_ni) begin
      verdict.ready <= 1'b0;
      hold_off      <= 0;
    end else if (hold_off > 1) begin
      hold_off <= hold_off - 1;
    end else if (hold_off == 1) begin
      hold_off      <= 0;
      verdict.ready <= 1'b1;
    end else if (verdict.valid && verdict.ready && !sink_calm) begin
      draw = $urandom_range(0, 11);
      hold_off      <= draw;
      verdict.ready <= (draw == 0);
    end else begin
      verdict.ready <= 1'b1;
    end
  end

  function automatic logic [IN_W-1:0] near(int c);
    int v;
    v = c + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    return IN_W'(v);
  endfunction

  function automatic logic [IN_W-1:0] span(int lo, int hi);
    return IN_W'($urandom_range(hi, lo));
  endfunction

  function automatic evid_t random_word();
    evid_t       w;
    int          kind;
    logic [95:0] raw;
    kind     = $urandom_range(0, 9);
    w.expl   = 1'b0;
    w.neg    = 1'b0;
    w.fwin   = ($urandom_range(0, 2) == 0);
    w.fmatch = ($urandom_range(0, 3) == 0);
    w.direct = 1'($urandom_range(0, 1));
    w.recent = 1'($urandom_range(0, 1));
    if (kind <= 2) begin
      w.intent  = span(2000, 4096);
      w.prox    = span(2000, 4096);
      w.asr     = span(2000, 4096);
      w.spk     = span(2000, 4096);
      w.media   = span(0, 2200);
      w.overlap = span(0, 2200);
    end else if (kind <= 5) begin
      w.intent  = span(0, 1800);
      w.prox    = span(0, 1800);
      w.asr     = span(0, 1800);
      w.spk     = span(0, 1800);
      w.media   = span(0, 3000);
      w.overlap = span(0, 3000);
    end else if (kind <= 7) begin
      w.intent  = span(0, 4096);
      w.prox    = span(0, 4096);
      w.asr     = span(0, 4096);
      w.spk     = span(0, 4096);
      w.media   = span(0, 4096);
      w.overlap = span(0, 4096);
      w.expl    = ($urandom_range(0, 9) == 0);
      w.neg     = ($urandom_range(0, 9) == 0);
    end else if (kind == 8) begin
      w.intent  = near(thr_f);
      w.prox    = near(thr_f);
      w.asr     = near(thr_f);
      w.spk     = near(thr_f);
      w.media   = ($urandom_range(0, 1) == 0) ? near(lvl_m) : near(2253);
      w.overlap = ($urandom_range(0, 1) == 0) ? near(lvl_o) : near(2253);
    end else begin
      raw = {$urandom, $urandom, $urandom};
      w   = evid_t'(raw[$bits(evid_t)-1:0]);
    end
    return w;
  endfunction

  task automatic send_word(input evid_t w);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      evid.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evid.valid            <= 1'b1;
    evid.intent_score     <= w.intent;
    evid.proximity_score  <= w.prox;
    evid.recog_confidence <= w.asr;
    evid.speaker_score    <= w.spk;
    evid.media_score      <= w.media;
    evid.overlap_score    <= w.overlap;
    evid.explicit_flag    <= w.expl;
    evid.negative_flag    <= w.neg;
    evid.followup_window  <= w.fwin;
    evid.followup_match   <= w.fmatch;
    evid.direct_flag      <= w.direct;
    evid.recent_flag      <= w.recent;
    @(posedge clk_i);
    while (!evid.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_fields(input int intent, input int prox, input int asr,
                             input int spk, input int media, input int ovl,
                             input logic [5:0] flags);
    evid_t w;
    w.intent  = IN_W'(intent);
    w.prox    = IN_W'(prox);
    w.asr     = IN_W'(asr);
    w.spk     = IN_W'(spk);
    w.media   = IN_W'(media);
    w.overlap = IN_W'(ovl);
    {w.expl, w.neg, w.fwin, w.fmatch, w.direct, w.recent} = flags;
    send_word(w);
  endtask

  task automatic settle();
    int waited;
    evid.valid <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < 4000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic set_levels(input int f, input int a, input int r, input int m,
                            input int o, input int n);
    write_reg(CFG_FAMILY_THR, CFG_W'(f));
    write_reg(CFG_ACCEPT_LVL, CFG_W'(a));
    write_reg(CFG_REJECT_LVL, CFG_W'(r));
    write_reg(CFG_MEDIA_LVL, CFG_W'(m));
    write_reg(CFG_OVERLAP_LVL, CFG_W'(o));
    write_reg(CFG_MIN_FAM, (CFG_W'($urandom) & 13'h1FF8) | CFG_W'(n & 7));
    write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B, CFG_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk_i);
    thr_f = f;
    lvl_m = m;
    lvl_o = o;
    settings_used++;
  endtask

  initial begin : stimulus
    int a, leftover;
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    evid.valid            <= 1'b0;
    evid.intent_score     <= '0;
    evid.proximity_score  <= '0;
    evid.recog_confidence <= '0;
    evid.speaker_score    <= '0;
    evid.media_score      <= '0;
    evid.overlap_score    <= '0;
    evid.explicit_flag    <= 1'b0;
    evid.negative_flag    <= 1'b0;
    evid.followup_window  <= 1'b0;
    evid.followup_match   <= 1'b0;
    evid.direct_flag      <= 1'b0;
    evid.recent_flag      <= 1'b0;
    words_sent    = 0;
    settings_used = 1;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    thr_f         = 2458;
    lvl_m         = 3277;
    lvl_o         = 3277;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_fields(0, 0, 0, 0, 0, 0, F_EXPL);
    send_fields(8191, 8191, 8191, 8191, 8191, 8191, F_EXPL | F_NEG);
    send_fields(4096, 4096, 4096, 4096, 0, 0, F_NEG);
    send_fields(1000, 1000, 1000, 1000, 3277, 0, F_NONE);
    send_fields(1000, 1000, 1000, 1000, 3276, 3277, F_NONE);
    send_fields(0, 0, 0, 0, 4096, 4096, F_NONE);
    send_fields(0, 0, 0, 0, 3277, 0, F_NEG);
    send_fields(0, 0, 0, 0, 0, 0, F_FWIN | F_FMATCH);
    send_fields(4096, 0, 4096, 0, 2252, 2252, F_FWIN | F_FMATCH);
    send_fields(4096, 0, 4096, 0, 2253, 0, F_FWIN | F_FMATCH);
    send_fields(3000, 3000, 3000, 3000, 0, 0, F_FWIN);
    send_fields(4096, 4096, 4096, 4096, 0, 0, F_DIRECT | F_RECENT | F_FWIN);
    send_fields(0, 0, 0, 0, 3276, 3276, F_NONE);
    send_fields(8191, 8191, 8191, 8191, 0, 0, F_DIRECT);
    send_fields(2458, 2457, 2458, 2457, 0, 0, F_DIRECT);
    send_fields(2000, 2000, 2000, 2000, 500, 500, F_NONE);
    send_fields(4096, 0, 0, 0, 0, 0, F_RECENT | F_DIRECT);
    send_fields(5461, 2730, 5461, 2730, 2730, 1365, F_RECENT | F_FMATCH);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1: set_levels(0, 0, 0, 4096, 4096, 0);
          2: set_levels(8191, 8191, 8191, 8191, 8191, 7);
          3: set_levels(4096, 4096, 4096, 0, 0, 6);
          4: set_levels($urandom_range(1500, 3000), 1500, 2600, 3500, 3500, 1);
          5: set_levels(2458, 2867, 1229, 3277, 3277, 2);
          default: begin
            a = $urandom_range(1800, 3600);
            set_levels($urandom_range(1000, 3500), a, $urandom_range(0, a - 1),
                       $urandom_range(2000, 4096), $urandom_range(2000, 4096),
                       $urandom_range(1, 6));
          end
        endcase
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
        if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
        if (phase == 6 && k == WORDS_PER_PHASE / 2) settle();
        send_word(random_word());
      end
    end
    settle();
    repeat (20) @(posedge clk_i);

    leftover = pending;
    if (leftover != 0)
      $display("%0t ns: %0d verdicts still outstanding at the end", $time, leftover);
    $display("Sent %0d evidence words under %0d register settings; %0d verdicts compared.",
             words_sent, settings_used, compared);
    $display("Reason codes seen (bit per code): %b", reasons);
    if (errors == 0 && leftover == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Run timed out.");
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
